/* hw/rtl/gvtd_pkg.sv */
// shared types and constants of the guarded valve timer with command dedup
package gvtd_pkg;

	// dedup ring
	localparam int SEEN_DEPTH = 8;
	localparam int ID_BITS    = 64;
	localparam int SLOT_W     = $clog2(SEEN_DEPTH);

	// field widths
	localparam int DUR_W  = 20;
	localparam int FLOW_W = 16;
	localparam int VOL_W  = 27;
	localparam int CFG_W  = 20;

	// register reset values
	localparam logic [DUR_W-1:0]  MAX_OPEN_RESET = DUR_W'(30000);
	localparam logic [FLOW_W-1:0] FLOW_RESET     = FLOW_W'(10);

	// volume = (granted * flow + 500) / 1000, with 1000 = 8 * 125
	localparam int              PROD_W       = DUR_W + FLOW_W;
	localparam logic [8:0]      VOL_ROUND    = 9'd500;
	localparam int              DIV_PRE_SHIFT = 3;
	localparam int              DIV_ODD      = 125;
	localparam int              RECIP_W      = 32;
	localparam logic [31:0]     RECIP_125    = 32'd2199023255;  // floor(2^38 / 125)

	// request kinds
	localparam logic [1:0] REQ_OPEN = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_LOST = 2'd2;

	// register indexes
	localparam logic [1:0] CFG_MAX_OPEN = 2'd0;
	localparam logic [1:0] CFG_FLOW     = 2'd1;
	localparam logic [1:0] CFG_DRIVE    = 2'd2;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_OPENED = 3'd1,
		EV_CLOSED = 3'd2,
		EV_DUP    = 3'd3,
		EV_EMPTY  = 3'd4,
		EV_ZERO   = 3'd5
	} ev_t;

	// result fields known right after the decision stage
	typedef struct packed {
		ev_t              ev;
		logic             drive;
		logic [DUR_W-1:0] granted;
		logic             reason;
	} res_t;

endpackage

/* hw/rtl/gvtd_dedup.sv */
// ring of recently seen command ids with parallel lookup
module gvtd_dedup import gvtd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ID_BITS-1:0] id,
	input  logic               store,
	output logic               hit
);

	logic [ID_BITS-1:0]    ids_q [SEEN_DEPTH];
	logic [SEEN_DEPTH-1:0] valid_q;
	logic [SLOT_W-1:0]     slot_q;

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < SEEN_DEPTH; i++) begin
			if (valid_q[i] && ids_q[i] == id) begin
				hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			slot_q  <= '0;
		end else if (store) begin
			valid_q[slot_q] <= 1'b1;
			if (slot_q == SLOT_W'(SEEN_DEPTH - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			ids_q[slot_q] <= id;
		end
	end

endmodule

/* hw/rtl/gvtd_volume.sv */
// pipelined volume calculation: product, reciprocal multiply, remainder fix
module gvtd_volume import gvtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [FLOW_W-1:0] flow,
	input  logic              in_valid,
	output logic              in_ready,
	input  res_t              in_res,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              out_res,
	output logic [VOL_W-1:0]  out_vol
);

	localparam int Y_W = PROD_W - DIV_PRE_SHIFT;
	localparam int A_W = PROD_W - DIV_PRE_SHIFT - 6;
	localparam int T_W = A_W + RECIP_W;
	localparam int R_W = Y_W + 1;

	logic              v_s2, v_s3, v_q;
	logic              rdy_s2, rdy_s3, rdy_q;
	res_t              res_s2, res_s3, res_q;
	logic [PROD_W-1:0] prod_s2;
	logic [Y_W-1:0]    y_s3;
	logic [T_W-1:0]    t_s3;
	logic [VOL_W-1:0]  vol_q;

	logic [A_W-1:0]   a;
	logic [VOL_W-1:0] q_est;
	logic [R_W-1:0]   q_mul;
	logic [R_W-1:0]   r_full;
	logic [8:0]       r;
	logic [VOL_W-1:0] q_fix;

	assign rdy_q    = !v_q || out_ready;
	assign rdy_s3   = !v_s3 || rdy_q;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	// floor(y / 125) estimate, low by at most one
	assign a      = prod_s2[PROD_W-1:PROD_W-A_W];
	assign q_est  = t_s3[T_W-1:RECIP_W];
	assign q_mul  = R_W'(q_est) * R_W'(DIV_ODD);
	assign r_full = R_W'(y_s3) - q_mul;
	assign r      = r_full[8:0];

	always_comb begin
		if (r >= 9'(2 * DIV_ODD)) begin
			q_fix = q_est + VOL_W'(2);
		end else if (r >= 9'(DIV_ODD)) begin
			q_fix = q_est + VOL_W'(1);
		end else begin
			q_fix = q_est;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= in_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_q)  v_q  <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			res_s2  <= in_res;
			prod_s2 <= PROD_W'(in_res.granted) * PROD_W'(flow) + PROD_W'(VOL_ROUND);
		end
		if (rdy_s3 && v_s2) begin
			res_s3 <= res_s2;
			y_s3   <= prod_s2[PROD_W-1:DIV_PRE_SHIFT];
			t_s3   <= T_W'(a) * T_W'(RECIP_125);
		end
		if (rdy_q && v_s3) begin
			res_q <= res_s3;
			vol_q <= q_fix;
		end
	end

	assign out_valid = v_q;
	assign out_res   = res_q;
	assign out_vol   = vol_q;

endmodule

/* hw/rtl/guarded_valve_timer_dedup.sv */
// top level of the guarded valve timer with command id dedup
//
// usage
//   s_axis carries one request per transaction: tuser holds the kind (open
//   command, one millisecond tick, link lost), tdata the command id and the
//   requested duration. m_axis returns exactly one result per request: tuser
//   holds the event code, tdata the pin level, granted time, volume and close
//   reason. the cfg channel writes max_open_ms, flow_ml_per_s and
//   drive_active_high by index; write it only while no request is in flight.
// timing
//   one request per cycle sustained while m_axis_tready stays high. valve
//   state, timer, id ring and the decision register update at the accepting
//   edge; from there the result passes the product stage, the reciprocal
//   multiply stage and the remainder correction into the output register.
//   the volume division by 1000 sets the depth of this pipeline.
// reset
//   arst_n clears the id ring valid bits, closes the valve, zeroes the timer
//   and loads the register defaults; the pipeline comes up empty.
// stall
//   each stage holds while the next one is full, so up to four results queue
//   before s_axis_tready drops; no transaction is lost or repeated.
module guarded_valve_timer_dedup import gvtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// request stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [87:0]       s_axis_tdata,   // cmd_id[63:0], duration_ms[83:64], zero pad
	input  logic [1:0]        s_axis_tuser,   // req_type[1:0]
	// result stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [55:0]       m_axis_tdata,   // valve_drive[0], granted_ms[20:1],
	                                          // volume_ml[47:21], close_reason[48], zero pad
	output logic [2:0]        m_axis_tuser,   // event_res[2:0]
	// register writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	// configuration registers
	logic [DUR_W-1:0]  max_open_q;
	logic [FLOW_W-1:0] flow_q;
	logic              drive_high_q;

	// valve state
	logic              open_q;
	logic [DUR_W-1:0]  rem_q;

	// request fields
	logic [1:0]        req_type;
	logic [ID_BITS-1:0] cmd_id;
	logic [DUR_W-1:0]  duration_ms;

	// decision logic
	logic              accept;
	logic              id_hit;
	logic              id_store;
	logic [DUR_W-1:0]  capped;
	logic              open_d;
	logic [DUR_W-1:0]  rem_d;
	res_t              res_d;

	// decision register
	logic              v_s1;
	res_t              res_s1;
	logic              vol_in_ready;

	// output side
	res_t              out_res;
	logic [VOL_W-1:0]  out_vol;

	assign req_type    = s_axis_tuser;
	assign cmd_id      = s_axis_tdata[ID_BITS-1:0];
	assign duration_ms = s_axis_tdata[64 +: DUR_W];

	// registers are always writable, an unknown index is dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_open_q   <= MAX_OPEN_RESET;
			flow_q       <= FLOW_RESET;
			drive_high_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_OPEN: max_open_q   <= cfg_data[DUR_W-1:0];
				CFG_FLOW:     flow_q       <= cfg_data[FLOW_W-1:0];
				CFG_DRIVE:    drive_high_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// decision register accepts whenever it is empty or moving on
	assign s_axis_tready = !v_s1 || vol_in_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// a new nonempty id goes into the ring even when its duration is zero
	assign id_store = accept && req_type == REQ_OPEN && cmd_id != '0 && !id_hit;

	gvtd_dedup u_dedup (
		.clk    (clk),
		.arst_n (arst_n),
		.id     (cmd_id),
		.store  (id_store),
		.hit    (id_hit)
	);

	assign capped = (duration_ms > max_open_q) ? max_open_q : duration_ms;

	always_comb begin
		open_d        = open_q;
		rem_d         = rem_q;
		res_d.ev      = EV_NONE;
		res_d.granted = '0;
		res_d.reason  = 1'b0;
		case (req_type)
			REQ_OPEN: begin
				if (cmd_id == '0) begin
					res_d.ev = EV_EMPTY;
				end else if (id_hit) begin
					res_d.ev = EV_DUP;
				end else if (capped == '0) begin
					res_d.ev = EV_ZERO;
				end else begin
					// opens, or restarts the timer when already open
					open_d        = 1'b1;
					rem_d         = capped;
					res_d.ev      = EV_OPENED;
					res_d.granted = capped;
				end
			end
			REQ_TICK: begin
				if (open_q) begin
					if (rem_q <= DUR_W'(1)) begin
						open_d   = 1'b0;
						rem_d    = '0;
						res_d.ev = EV_CLOSED;
					end else begin
						rem_d = rem_q - DUR_W'(1);
					end
				end
			end
			REQ_LOST: begin
				if (open_q) begin
					open_d       = 1'b0;
					rem_d        = '0;
					res_d.ev     = EV_CLOSED;
					res_d.reason = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// pin level after this request
		res_d.drive = open_d ? drive_high_q : !drive_high_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			rem_q  <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (accept) begin
				open_q <= open_d;
				rem_q  <= rem_d;
			end
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	// volume pipeline and output register
	gvtd_volume u_volume (
		.clk       (clk),
		.arst_n    (arst_n),
		.flow      (flow_q),
		.in_valid  (v_s1),
		.in_ready  (vol_in_ready),
		.in_res    (res_s1),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res),
		.out_vol   (out_vol)
	);

	assign m_axis_tuser = out_res.ev;
	assign m_axis_tdata = {7'b0, out_res.reason, out_vol, out_res.granted, out_res.drive};

	// a closed valve never holds time on its timer
	a_closed_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> rem_q == '0)
		else $error("closed valve holds a nonzero timer");

	// a lost link leaves the valve closed
	a_lost_closes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_LOST |=> !open_q)
		else $error("valve still open after link lost");

	// only an opened event reports granted time and volume
	a_no_grant_unless_opened: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_res.ev != EV_OPENED |-> out_res.granted == '0 && out_vol == '0)
		else $error("granted time or volume on a non-open result");

	// a duplicate never touches valve state
	a_dup_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_OPEN && cmd_id != '0 && id_hit
		|=> open_q == $past(open_q) && rem_q == $past(rem_q))
		else $error("duplicate command changed the valve state");

endmodule
